### sv/dsp_pkg.sv
// Shared types and constants for the dense shortest-path block.
// No dependencies.
`timescale 1ns / 1ps
package dsp_pkg;

   localparam int WEIGHT_W  = 15;
   localparam int DIST_W    = 20;
   localparam int VERT_W    = 3;
   localparam int CNT_W     = 4;
   localparam int MAX_VERTS = 8;
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_RELAX,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [VERT_W-1:0] pred;
   } dist_entry_type;

endpackage

### sv/dsp_wmem.sv
// Edge weight memory: one write port, one read port, registered read data.
// Depends on dsp_pkg.
`timescale 1ns / 1ps
module dsp_wmem import dsp_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [WEIGHT_W-1:0] wr_data,
   input  logic [AW-1:0]       rd_addr,
   output logic [WEIGHT_W-1:0] rd_data
);

   logic [WEIGHT_W-1:0] mem [DEPTH];
   logic [WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dsp_dmem.sv
// Distance / predecessor memory: one write port, one read port, registered read.
// Depends on dsp_pkg.
`timescale 1ns / 1ps
module dsp_dmem import dsp_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  dist_entry_type wr_data,
   input  logic [AW-1:0]  rd_addr,
   output dist_entry_type rd_data
);

   dist_entry_type mem [DEPTH];
   dist_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/dsp_ctrl.sv
// Search sequencer: init, min scan, relax sweeps and result output register.
// Depends on dsp_pkg, dsp_wmem and dsp_dmem.
`timescale 1ns / 1ps
module dsp_ctrl import dsp_pkg::*; #(
   parameter int NUM_VERTICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  vertices_in_use,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_cmd,
   input  logic [VERT_W-1:0] req_row,
   input  logic [VERT_W-1:0] req_col,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic [VERT_W-1:0] req_source,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [VERT_W-1:0] rsp_vertex,
   output logic [DIST_W-1:0] rsp_distance,
   output logic [VERT_W-1:0] rsp_pred,
   output logic              rsp_tlast
);

   localparam int VN = (NUM_VERTICES < MAX_VERTS) ? NUM_VERTICES : MAX_VERTS;
   localparam int VW = $clog2(VN);
   localparam int AW = $clog2(VN * VN);
   localparam logic [CNT_W-1:0] VN_C = CNT_W'(VN);

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [VERT_W-1:0] src_ff, src_in;
   logic [CNT_W-1:0]  round_ff, round_in;
   logic [VN-1:0]     settled_ff, settled_in;
   logic              found_ff, found_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [VERT_W-1:0] vx_ff, vx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VERT_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [VERT_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]    n_req;
   logic                req_fire, rsp_fire, issue, last_data, take, idx_settled;
   logic [VERT_W-1:0]   base_v;
   logic                wm_we, dm_we;
   logic [AW-1:0]       wm_waddr, wm_raddr;
   logic [WEIGHT_W-1:0] wm_rdata;
   logic [VW-1:0]       dm_waddr;
   dist_entry_type      dm_wdata, dm_rdata;
   logic [DIST_W:0]     sum;
   logic [DIST_W-1:0]   cand;

   dsp_wmem #(.DEPTH(VN * VN), .AW(AW)) u_wmem (
      .clock   (clock),
      .wr_en   (wm_we),
      .wr_addr (wm_waddr),
      .wr_data (req_weight),
      .rd_addr (wm_raddr),
      .rd_data (wm_rdata)
   );

   dsp_dmem #(.DEPTH(VN), .AW(VW)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (cnt_ff[VW-1:0]),
      .rd_data (dm_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   always_comb begin
      if (vertices_in_use == '0) begin
         n_req = CNT_W'(1);
      end else if (vertices_in_use > VN_C) begin
         n_req = VN_C;
      end else begin
         n_req = vertices_in_use;
      end
   end

   assign base_v    = (state_ff == ST_INIT) ? src_ff : vx_ff;
   assign wm_raddr  = AW'(int'(base_v) * VN + int'(cnt_ff));
   assign wm_waddr  = AW'(int'(req_row) * VN + int'(req_col));
   assign wm_we     = req_fire && (req_cmd == CMD_WRITE) &&
                      ({1'b0, req_row} < VN_C) && ({1'b0, req_col} < VN_C);
   assign last_data = rd_vld_ff && (rd_idx_ff == CNT_W'(n_ff - CNT_W'(1)));
   assign idx_settled = settled_ff[rd_idx_ff[VW-1:0]];
   assign take      = !idx_settled && (!found_ff || (dm_rdata.distance < best_ff));
   assign sum       = {1'b0, best_ff} + (DIST_W+1)'(wm_rdata);
   assign cand      = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
   assign dm_waddr  = rd_idx_ff[VW-1:0];

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      src_in        = src_ff;
      round_in      = round_ff;
      settled_in    = settled_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      vx_in         = vx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_pred_in   = rsp_pred_ff;
      rsp_last_in   = rsp_last_ff;
      dm_we         = 1'b0;
      dm_wdata      = dm_rdata;
      issue         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire && (req_cmd == CMD_RUN) && ({1'b0, req_source} < n_req)) begin
               n_in     = n_req;
               src_in   = req_source;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            issue = (cnt_ff < n_ff);
            if (rd_vld_ff) begin
               dm_we    = 1'b1;
               dm_wdata = '{distance: DIST_W'(wm_rdata), pred: src_ff};
            end
            if (last_data) begin
               settled_in                = '0;
               settled_in[src_ff[VW-1:0]] = 1'b1;
               round_in                  = CNT_W'(1);
               found_in                  = 1'b0;
               cnt_in                    = '0;
               state_in = (n_ff == CNT_W'(1)) ? ST_OUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue = (cnt_ff < n_ff);
            if (rd_vld_ff && take) begin
               found_in = 1'b1;
               best_in  = dm_rdata.distance;
               vx_in    = VERT_W'(rd_idx_ff);
            end
            if (last_data) begin
               settled_in[vx_in[VW-1:0]] = 1'b1;
               cnt_in   = '0;
               state_in = ST_RELAX;
            end
         end
         ST_RELAX: begin
            issue = (cnt_ff < n_ff);
            if (rd_vld_ff && !idx_settled && (dm_rdata.distance > cand)) begin
               dm_we    = 1'b1;
               dm_wdata = '{distance: cand, pred: vx_ff};
            end
            if (last_data) begin
               round_in = round_ff + CNT_W'(1);
               found_in = 1'b0;
               cnt_in   = '0;
               state_in = (round_in == n_ff) ? ST_OUT : ST_SCAN;
            end
         end
         ST_OUT: begin
            issue = (cnt_ff < n_ff) && !rd_vld_ff && (!rsp_valid_ff || rsp_tready);
            if (rd_vld_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = VERT_W'(rd_idx_ff);
               rsp_dist_in   = dm_rdata.distance;
               rsp_pred_in   = dm_rdata.pred;
               rsp_last_in   = last_data;
            end
            if (last_data) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rd_vld_in = issue;
      rd_idx_in = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         n_ff         <= CNT_W'(1);
         round_ff     <= '0;
         settled_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         n_ff         <= n_in;
         round_ff     <= round_in;
         settled_ff   <= settled_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      src_ff        <= src_in;
      best_ff       <= best_in;
      vx_ff         <= vx_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_pred_ff   <= rsp_pred_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_vertex   = rsp_vertex_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_pred     = rsp_pred_ff;
   assign rsp_tlast    = rsp_last_ff;

   a_relax_pivot_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> settled_ff[vx_ff[VW-1:0]])
      else $error("relax pivot not settled");

   a_scan_has_candidate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ($countones(settled_ff) < int'(n_ff)))
      else $error("scan with every vertex settled");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rd_vld_ff) |-> !rsp_valid_ff)
      else $error("result register overwritten");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_vld_ff)
      else $error("read in flight while idle");

endmodule

### sv/dense_shortest_path.sv
// Dense single-source shortest paths over an edge-weight matrix memory.
// Weight writes are accepted back to back while idle. A run of n vertices does an
// init sweep, then n-1 rounds of a scan and a relax sweep, then reads out the
// results one at a time: a new read waits until the previous one has landed and
// the result register is free.
// Reset clears control state and sets vertices_in_use to 7; weights undefined.
`timescale 1ns / 1ps
module dense_shortest_path import dsp_pkg::*; #(
   parameter int NUM_VERTICES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [3:0]  csr_wdata,    // vertices_in_use
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // row[2:0], col[5:3], weight[20:6], source[23:21]
   input  logic        req_tuser,    // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // vertex[2:0], distance[22:3], predecessor[25:23]
   output logic        rsp_tlast
);

   logic [CNT_W-1:0]  csr_ff, csr_in;
   logic [VERT_W-1:0] rsp_vertex, rsp_pred;
   logic [DIST_W-1:0] rsp_distance;

   assign csr_in = csr_wen ? csr_wdata : csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CNT_W'(7);
      end else begin
         csr_ff <= csr_in;
      end
   end

   dsp_ctrl #(.NUM_VERTICES(NUM_VERTICES)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .vertices_in_use (csr_ff),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_cmd         (req_tuser),
      .req_row         (req_tdata[2:0]),
      .req_col         (req_tdata[5:3]),
      .req_weight      (req_tdata[20:6]),
      .req_source      (req_tdata[23:21]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_vertex      (rsp_vertex),
      .rsp_distance    (rsp_distance),
      .rsp_pred        (rsp_pred),
      .rsp_tlast       (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rsp_pred, rsp_distance, rsp_vertex};

endmodule
